[hw/rtl/spit_pkg.sv]
`timescale 1ns / 1ps
// spit_pkg: types, codes and field helpers for the speed profile table
// used by spit_ctrl, spit_dp and the top level; no dependencies
package spit_pkg;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_TIME   = 2'd1;
    localparam logic [1:0] KIND_DIST   = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [2:0] FLD_DIST  = 3'd0;
    localparam logic [2:0] FLD_STAMP = 3'd1;
    localparam logic [2:0] FLD_SPEED = 3'd2;
    localparam logic [2:0] FLD_ACCEL = 3'd3;
    localparam logic [2:0] FLD_JERK  = 3'd4;
    localparam logic [2:0] FLD_END   = 3'd5;

    localparam logic [1:0] ADDR_MID  = 2'd0;
    localparam logic [1:0] ADDR_LOM1 = 2'd1;
    localparam logic [1:0] ADDR_LO   = 2'd2;
    localparam logic [1:0] ADDR_ZERO = 2'd3;

    typedef struct packed {
        logic signed [31:0] distance;
        logic signed [31:0] stamp;
        logic signed [31:0] speed;
        logic signed [31:0] accel;
        logic signed [31:0] jerk;
    } point_t;

    typedef struct packed {
        logic       load;
        logic       exec;
        logic       srch_cmp;
        logic [1:0] rd_sel;
        logic       cap_x0;
        logic       cap_x1;
        logic       take_entry;
        logic       prep;
        logic       fld_clr;
        logic       fld_next;
        logic       key_res;
        logic       diff;
        logic       mul;
        logic       div_start;
        logic       wr_res;
        logic       push;
    } spit_cmd_t;

    typedef struct packed {
        logic query_go;
        logic n_zero;
        logic lo_zero;
        logic fld_done;
        logic fld_is_key;
        logic div_done;
        logic out_free;
    } spit_sts_t;

    function automatic logic signed [31:0] get_field(input point_t p, input logic [2:0] f);
        logic signed [31:0] v;
        case (f)
            FLD_DIST:  v = p.distance;
            FLD_STAMP: v = p.stamp;
            FLD_SPEED: v = p.speed;
            FLD_ACCEL: v = p.accel;
            default:   v = p.jerk;
        endcase
        return v;
    endfunction

    function automatic point_t set_field(input point_t p, input logic [2:0] f,
                                         input logic signed [31:0] v);
        point_t r;
        r = p;
        case (f)
            FLD_DIST:  r.distance = v;
            FLD_STAMP: r.stamp = v;
            FLD_SPEED: r.speed = v;
            FLD_ACCEL: r.accel = v;
            default:   r.jerk = v;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
            r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7fff_ffff)
            r = 32'sh7fff_ffff;
        else if (v < -34'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[hw/rtl/spit_div.sv]
`timescale 1ns / 1ps
// spit_div: restoring 64 by 32 divider, one quotient bit per cycle
// depends on nothing; quotient must fit in 32 bits
module spit_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quot
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] low_reg;
    logic [32:0] sh;
    logic [32:0] trial;
    logic        ge;

    assign sh    = {rem_reg, low_reg[31]};
    assign trial = sh - {1'b0, divisor};
    assign ge    = sh >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[63:32];
            low_reg <= dividend[31:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? trial[31:0] : sh[31:0];
            low_reg <= {low_reg[30:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = low_reg;

endmodule

[hw/rtl/spit_ctrl.sv]
`timescale 1ns / 1ps
// spit_ctrl: sequencer for append, clear, search and interpolation
// depends on spit_pkg
module spit_ctrl
    import spit_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  spit_sts_t sts,
    output spit_cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_SRCH  = 4'd2;
    localparam logic [3:0] S_SCMP  = 4'd3;
    localparam logic [3:0] S_ENT   = 4'd4;
    localparam logic [3:0] S_RDA   = 4'd5;
    localparam logic [3:0] S_CAPB  = 4'd6;
    localparam logic [3:0] S_PREP  = 4'd7;
    localparam logic [3:0] S_FSEL  = 4'd8;
    localparam logic [3:0] S_FDIFF = 4'd9;
    localparam logic [3:0] S_FMUL  = 4'd10;
    localparam logic [3:0] S_FDIV  = 4'd11;
    localparam logic [3:0] S_FWAIT = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = ADDR_MID;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.query_go ? S_SRCH : S_FIN;
            end
            S_SRCH:
            begin
                if (!sts.n_zero)
                begin
                    cmd.rd_sel = ADDR_MID;
                    state_next = S_SCMP;
                end
                else if (sts.lo_zero)
                begin
                    cmd.rd_sel = ADDR_ZERO;
                    state_next = S_ENT;
                end
                else
                begin
                    cmd.rd_sel = ADDR_LOM1;
                    state_next = S_RDA;
                end
            end
            S_SCMP:
            begin
                cmd.srch_cmp = 1'b1;
                state_next   = S_SRCH;
            end
            S_ENT:
            begin
                cmd.take_entry = 1'b1;
                state_next     = S_FIN;
            end
            S_RDA:
            begin
                cmd.cap_x0 = 1'b1;
                cmd.rd_sel = ADDR_LO;
                state_next = S_CAPB;
            end
            S_CAPB:
            begin
                cmd.cap_x1 = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep    = 1'b1;
                cmd.fld_clr = 1'b1;
                state_next  = S_FSEL;
            end
            S_FSEL:
            begin
                if (sts.fld_done)
                    state_next = S_FIN;
                else if (sts.fld_is_key)
                begin
                    cmd.key_res  = 1'b1;
                    cmd.fld_next = 1'b1;
                end
                else
                    state_next = S_FDIFF;
            end
            S_FDIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_FMUL;
            end
            S_FMUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_FDIV;
            end
            S_FDIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_FWAIT;
            end
            S_FWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.wr_res   = 1'b1;
                    cmd.fld_next = 1'b1;
                    state_next   = S_FSEL;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

[hw/rtl/spit_dp.sv]
`timescale 1ns / 1ps
// spit_dp: point memory, search registers, interpolation arithmetic, output beat
// depends on spit_pkg and spit_div
module spit_dp
    import spit_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  spit_cmd_t          cmd,
    output spit_sts_t          sts,
    input  logic [1:0]         kind,
    input  logic signed [31:0] dist_req,
    input  logic signed [31:0] stamp,
    input  logic signed [31:0] speed,
    input  logic signed [31:0] accel,
    input  logic signed [31:0] jerk,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] out_dist,
    output logic signed [31:0] out_stamp,
    output logic signed [31:0] out_speed,
    output logic signed [31:0] out_accel,
    output logic signed [31:0] out_jerk,
    output logic signed [31:0] span_time,
    output logic signed [31:0] span_dist
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    point_t mem [TABLE_DEPTH];
    point_t rdata_reg;

    logic [CW-1:0]      count_reg;
    logic               out_valid_reg;
    logic [1:0]         kind_reg;
    point_t             in_reg;
    logic signed [31:0] first_dist_reg;
    logic signed [31:0] first_stamp_reg;
    logic signed [31:0] last_dist_reg;
    logic signed [31:0] last_stamp_reg;
    logic [1:0]         status_reg;
    point_t             res_reg;
    logic [CW-1:0]      lo_reg;
    logic [CW-1:0]      n_reg;
    point_t             x0_reg;
    point_t             x1_reg;
    logic [2:0]         fld_reg;
    logic [31:0]        a_reg;
    logic [31:0]        den_reg;
    logic [31:0]        m_reg;
    logic               neg_reg;
    logic [63:0]        prod_reg;
    logic [1:0]         ostat_reg;
    point_t             opt_reg;
    logic signed [31:0] ospan_t_reg;
    logic signed [31:0] ospan_d_reg;

    logic [2:0]         kf;
    logic signed [31:0] q;
    logic signed [31:0] first_key;
    logic signed [31:0] last_key;
    logic               full;
    logic               order_bad;
    logic               fail;
    logic               is_query;
    logic               append_ok;
    logic [CW-1:0]      half;
    logic [CW-1:0]      mid;
    logic [CW-1:0]      lo_m1;
    logic [AW-1:0]      rd_addr;
    logic signed [31:0] key_rd;
    logic signed [31:0] x0k;
    logic signed [31:0] x1k;
    logic signed [31:0] x1f;
    logic signed [32:0] a_full;
    logic signed [32:0] den_full;
    logic signed [32:0] fdiff;
    logic signed [32:0] fdiff_neg;
    logic signed [31:0] x0f;
    logic signed [33:0] isum;
    logic signed [31:0] ires;
    logic signed [32:0] st_diff;
    logic signed [32:0] sd_diff;
    logic               div_done;
    logic [31:0]        quot;

    assign kf        = (kind_reg == KIND_TIME) ? FLD_STAMP : FLD_DIST;
    assign q         = get_field(in_reg, kf);
    assign first_key = (kind_reg == KIND_TIME) ? first_stamp_reg : first_dist_reg;
    assign last_key  = (kind_reg == KIND_TIME) ? last_stamp_reg : last_dist_reg;
    assign full      = (count_reg == CW'(TABLE_DEPTH));
    assign order_bad = (count_reg != '0) && !(last_stamp_reg < in_reg.stamp);
    assign fail      = (count_reg < CW'(2)) || (q < first_key) || (q > last_key);
    assign is_query  = (kind_reg == KIND_TIME) || (kind_reg == KIND_DIST);
    assign append_ok = (kind_reg == KIND_APPEND) && !full && !order_bad;

    assign half   = n_reg >> 1;
    assign mid    = lo_reg + half;
    assign lo_m1  = lo_reg - CW'(1);
    assign key_rd = get_field(rdata_reg, kf);

    always_comb
    begin
        case (cmd.rd_sel)
            ADDR_MID:  rd_addr = mid[AW-1:0];
            ADDR_LOM1: rd_addr = lo_m1[AW-1:0];
            ADDR_LO:   rd_addr = lo_reg[AW-1:0];
            default:   rd_addr = '0;
        endcase
    end

    assign x0k       = get_field(x0_reg, kf);
    assign x1k       = get_field(x1_reg, kf);
    assign x1f       = get_field(x1_reg, fld_reg);
    assign a_full    = {q[31], q} - {x0k[31], x0k};
    assign den_full  = {x1k[31], x1k} - {x0k[31], x0k};
    assign fdiff     = {x1f[31], x1f} - {x0f[31], x0f};
    assign fdiff_neg = -fdiff;
    assign x0f       = get_field(x0_reg, fld_reg);
    assign isum      = neg_reg ? ({{2{x0f[31]}}, x0f} - {2'b00, quot})
                               : ({{2{x0f[31]}}, x0f} + {2'b00, quot});
    assign ires      = (den_reg == '0) ? x0f : sat34(isum);

    assign st_diff = {last_stamp_reg[31], last_stamp_reg} - {first_stamp_reg[31], first_stamp_reg};
    assign sd_diff = {last_dist_reg[31], last_dist_reg} - {first_dist_reg[31], first_dist_reg};

    spit_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quot     (quot)
    );

    // point memory
    always_ff @(posedge clk)
    begin
        if (cmd.exec && append_ok)
            mem[count_reg[AW-1:0]] <= in_reg;
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                if (append_ok)
                    count_reg <= count_reg + CW'(1);
                else if (kind_reg == KIND_CLEAR)
                    count_reg <= '0;
            end
            if (cmd.push)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            in_reg   <= '{distance: dist_req, stamp: stamp, speed: speed,
                          accel: accel, jerk: jerk};
        end
        if (cmd.exec)
        begin
            res_reg <= '0;
            lo_reg  <= '0;
            n_reg   <= count_reg;
            if (kind_reg == KIND_APPEND)
                status_reg <= full ? ST_FULL : (order_bad ? ST_ORDER : ST_OK);
            else if (is_query)
                status_reg <= fail ? ST_RANGE : ST_OK;
            else
                status_reg <= ST_OK;
            if (append_ok)
            begin
                if (count_reg == '0)
                begin
                    first_dist_reg  <= in_reg.distance;
                    first_stamp_reg <= in_reg.stamp;
                end
                last_dist_reg  <= in_reg.distance;
                last_stamp_reg <= in_reg.stamp;
            end
        end
        if (cmd.srch_cmp)
        begin
            if (key_rd < q)
            begin
                lo_reg <= mid + CW'(1);
                n_reg  <= n_reg - half - CW'(1);
            end
            else
                n_reg <= half;
        end
        if (cmd.cap_x0)
            x0_reg <= rdata_reg;
        if (cmd.cap_x1)
            x1_reg <= rdata_reg;
        if (cmd.take_entry)
            res_reg <= rdata_reg;
        if (cmd.prep)
        begin
            a_reg   <= a_full[31:0];
            den_reg <= den_full[31:0];
        end
        if (cmd.fld_clr)
            fld_reg <= FLD_DIST;
        else if (cmd.fld_next)
            fld_reg <= fld_reg + 3'd1;
        if (cmd.key_res)
            res_reg <= set_field(res_reg, fld_reg, q);
        if (cmd.diff)
        begin
            neg_reg <= fdiff[32];
            m_reg   <= fdiff[32] ? fdiff_neg[31:0] : fdiff[31:0];
        end
        if (cmd.mul)
            prod_reg <= {32'd0, a_reg} * {32'd0, m_reg};
        if (cmd.wr_res)
            res_reg <= set_field(res_reg, fld_reg, ires);
        if (cmd.push)
        begin
            ostat_reg   <= status_reg;
            opt_reg     <= res_reg;
            ospan_t_reg <= (count_reg == '0) ? 32'sd0 : sat33(st_diff);
            ospan_d_reg <= (count_reg == '0) ? 32'sd0 : sat33(sd_diff);
        end
    end

    assign sts.query_go   = is_query && !fail;
    assign sts.n_zero     = (n_reg == '0);
    assign sts.lo_zero    = (lo_reg == '0);
    assign sts.fld_done   = (fld_reg == FLD_END);
    assign sts.fld_is_key = (fld_reg == kf);
    assign sts.div_done   = div_done;
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign status    = ostat_reg;
    assign out_dist  = opt_reg.distance;
    assign out_stamp = opt_reg.stamp;
    assign out_speed = opt_reg.speed;
    assign out_accel = opt_reg.accel;
    assign out_jerk  = opt_reg.jerk;
    assign span_time = ospan_t_reg;
    assign span_dist = ospan_d_reg;

endmodule

[hw/rtl/speed_profile_interpolation_table.sv]
`timescale 1ns / 1ps
// speed_profile_interpolation_table: top level, one beat in and one beat out per item
// append and clear go from load through exec to the output; a query first runs a binary search,
// then copies the entry when it lands on the first entry, or else interpolates using the
// bit-serial divider, which is shared by four fields
// one item at a time; the next beat is taken while a result waits on the output
// reset clears the point count and control state; the point memory is not cleared
module speed_profile_interpolation_table
    import spit_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic signed [31:0] dist_req,
    input  logic signed [31:0] stamp,
    input  logic signed [31:0] speed,
    input  logic signed [31:0] accel,
    input  logic signed [31:0] jerk,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] out_dist,
    output logic signed [31:0] out_stamp,
    output logic signed [31:0] out_speed,
    output logic signed [31:0] out_accel,
    output logic signed [31:0] out_jerk,
    output logic signed [31:0] span_time,
    output logic signed [31:0] span_dist
);

    spit_cmd_t cmd;
    spit_sts_t sts;

    spit_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    spit_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .kind      (kind),
        .dist_req  (dist_req),
        .stamp     (stamp),
        .speed     (speed),
        .accel     (accel),
        .jerk      (jerk),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .out_dist  (out_dist),
        .out_stamp (out_stamp),
        .out_speed (out_speed),
        .out_accel (out_accel),
        .out_jerk  (out_jerk),
        .span_time (span_time),
        .span_dist (span_dist)
    );

endmodule
